### rtl/sps_pkg.sv
// Shared types and constants for the segment point sampler.
// No dependencies; every other file refers to it by scoped names.
package sps_pkg;

  localparam int MaxSteps = 63;
  localparam int NumLanes = 3;
  localparam int StepW    = 6;   // bits of the step count n
  localparam int RootW    = 33;  // bits of the integer square root
  localparam int RadW     = 66;  // bits of the squared length
  localparam int QuoW     = 34;  // bits of the lane dividend and quotient

  typedef struct packed {
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
  } seg_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last;
    logic               capped;
  } pt_out_t;

  typedef struct packed {
    logic             load;       // capture one axis of a new item
    logic             div_load;   // start the per-axis division
    logic             div_step;   // one quotient bit
    logic             emit_init;  // reset the offset accumulator
    logic             emit_step;  // advance to the next point
    logic [StepW-1:0] n;          // step count
  } lane_ctl_t;

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StSum,
    StSqrt,
    StNdiv,
    StLdiv,
    StEmit
  } state_e;

endpackage

### rtl/sps_lane.sv
// One coordinate axis of the sampler: delta, square, step division and
// the running offset of each emitted point. Depends on sps_pkg.
module sps_lane (
  input  logic                    clk_i,
  input  sps_pkg::lane_ctl_t      ctl_i,
  input  logic signed [31:0]      start_i,
  input  logic signed [31:0]      end_i,
  output logic [64:0]             sq_o,
  output logic signed [31:0]      point_o
);

  logic signed [31:0]          start_q;
  logic [32:0]                 mag_q;
  logic                        neg_q;
  logic [64:0]                 sq_q;
  logic [sps_pkg::QuoW-1:0]    div_q;
  logic [7:0]                  rem_q;
  logic [32:0]                 off_q;
  logic [7:0]                  er_q;

  logic signed [32:0]          delta;
  logic [65:0]                 prod;
  logic [7:0]                  den;
  logic [7:0]                  trial;
  logic [8:0]                  er_sum;
  logic [33:0]                 off_inc;
  logic signed [33:0]          pt_wide;
  logic signed [33:0]          off_s;

  assign delta = 33'(end_i) - 33'(start_i);
  assign prod  = {33'b0, mag_q} * {33'b0, mag_q};
  assign den   = {1'b0, ctl_i.n, 1'b0};
  assign trial = {rem_q[6:0], div_q[sps_pkg::QuoW-1]};
  assign er_sum = {1'b0, er_q} + {1'b0, rem_q};

  always_comb begin
    if (er_sum >= {1'b0, den}) begin
      off_inc = {1'b0, off_q} + {1'b0, div_q[32:0]} + 34'd1;
    end else begin
      off_inc = {1'b0, off_q} + {1'b0, div_q[32:0]};
    end
  end

  assign off_s   = {1'b0, off_q};
  assign pt_wide = neg_q ? (34'(start_q) - off_s) : (34'(start_q) + off_s);
  assign point_o = pt_wide[31:0];
  assign sq_o    = sq_q;

  always_ff @(posedge clk_i) begin
    sq_q <= prod[64:0];
    if (ctl_i.load) begin
      start_q <= start_i;
      neg_q   <= delta[32];
      mag_q   <= delta[32] ? 33'(-delta) : 33'(delta);
    end
    if (ctl_i.div_load) begin
      div_q <= {mag_q, 1'b0};
      rem_q <= '0;
    end else if (ctl_i.div_step) begin
      if (trial >= den) begin
        rem_q <= trial - den;
        div_q <= {div_q[sps_pkg::QuoW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        div_q <= {div_q[sps_pkg::QuoW-2:0], 1'b0};
      end
    end
    if (ctl_i.emit_init) begin
      off_q <= '0;
      er_q  <= {2'b0, ctl_i.n};
    end else if (ctl_i.emit_step) begin
      off_q <= off_inc[32:0];
      if (er_sum >= {1'b0, den}) begin
        er_q <= 8'(er_sum - {1'b0, den});
      end else begin
        er_q <= er_sum[7:0];
      end
    end
  end

endmodule

### rtl/sps_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle, with
// round-to-nearest on the result. Depends on sps_pkg.
module sps_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [sps_pkg::RadW-1:0]   rad_i,
  output logic                       done_o,
  output logic [sps_pkg::RootW:0]    len_o
);

  logic [sps_pkg::RadW-1:0]  rad_q;
  logic [sps_pkg::RootW-1:0] root_q;
  logic [34:0]               rem_q;
  logic [5:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;

  logic [36:0]               rem_sh;
  logic [36:0]               trial;
  logic [36:0]               diff;

  assign rem_sh = {rem_q, rad_q[sps_pkg::RadW-1 -: 2]};
  assign trial  = {2'b0, root_q, 2'b01};
  assign diff   = rem_sh - trial;
  assign done_o = done_q;
  assign len_o  = {1'b0, root_q} + ((rem_q > {2'b0, root_q}) ? 34'd1 : 34'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(sps_pkg::RootW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[sps_pkg::RadW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= diff[34:0];
        root_q <= {root_q[sps_pkg::RootW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[34:0];
        root_q <= {root_q[sps_pkg::RootW-2:0], 1'b0};
      end
    end
  end

endmodule

### rtl/sps_merge.sv
// Merging stage: gathers the three lane coordinates and the segment flags
// into one output item held in a register. Depends on sps_pkg.
module sps_merge (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic signed [31:0]  x_i,
  input  logic signed [31:0]  y_i,
  input  logic signed [31:0]  z_i,
  input  logic                last_i,
  input  logic                capped_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sps_pkg::pt_out_t    out_o
);

  logic             valid_q;
  sps_pkg::pt_out_t data_q;

  assign ready_o     = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q.point_x <= x_i;
      data_q.point_y <= y_i;
      data_q.point_z <= z_i;
      data_q.last    <= last_i;
      data_q.capped  <= capped_i;
    end
  end

endmodule

### rtl/segment_point_sampler.sv
// Segment point sampler: top level with the item sequencer.
// Uses sps_pkg, sps_lane, sps_sqrt and sps_merge.
//
// The block takes one 3-D segment per input item and returns n+1 evenly
// spaced points from start to end, where n is the rounded ratio of the
// segment length to the programmed spacing, limited to 63; on every point
// of a limited segment capped is set, and the final point carries last. A
// segment whose n rounds to zero yields only its start point. One segment
// occupies the block for these steps plus any output stall: capture the
// item, square the three deltas, sum them, run the one-bit-per-cycle
// square root unit and hand off its result, divide for the step count,
// run the per-axis quotient dividers, then emit n+1 points at one per
// cycle while the consumer keeps up. A segment whose n is zero skips the
// per-axis dividers. Most of the fixed work lies in the square root and
// the per-axis dividers. Each axis runs in a lane of its own; the merging
// stage packs the three coordinates into an output register, so a
// finished point can wait there for the consumer while the next one is
// formed. A new item is taken only once the previous segment has handed
// over its last point. The spacing register accepts a write only while
// the block is idle.
module segment_point_sampler (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sps_pkg::seg_in_t   in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sps_pkg::pt_out_t   out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [30:0]        cfg_data_i
);

  sps_pkg::state_e    state_q, state_d;
  logic [30:0]        step_q;
  logic [5:0]         cnt_q, cnt_d;
  logic [35:0]        num_q, num_d;
  logic [sps_pkg::StepW-1:0] n_q, n_d;
  logic [sps_pkg::StepW-1:0] j_q, j_d;
  logic               capped_q, capped_d;

  sps_pkg::lane_ctl_t ctl;
  logic [64:0]        sq [sps_pkg::NumLanes];
  logic signed [31:0] pt [sps_pkg::NumLanes];
  logic signed [31:0] st [sps_pkg::NumLanes];
  logic signed [31:0] en [sps_pkg::NumLanes];

  logic               sqrt_start;
  logic               sqrt_done;
  logic [sps_pkg::RootW:0] len;
  logic [65:0]        sum_sq;
  logic [30:0]        step_eff;
  logic [31:0]        den;
  logic [37:0]        den_sh;
  logic               pt_valid;
  logic               pt_ready;
  logic               is_last;

  assign st[0] = in_i.start_x;
  assign st[1] = in_i.start_y;
  assign st[2] = in_i.start_z;
  assign en[0] = in_i.end_x;
  assign en[1] = in_i.end_y;
  assign en[2] = in_i.end_z;

  // A zero step length acts as the smallest unsigned Q15.16 step.
  assign step_eff = (step_q == '0) ? 31'd1 : step_q;
  assign den      = {step_eff, 1'b0};
  assign den_sh   = {6'b0, den} << cnt_q;
  assign sum_sq   = {1'b0, sq[0]} + {1'b0, sq[1]} + {1'b0, sq[2]};
  assign is_last  = (j_q == n_q);

  assign in_ready_o  = (state_q == sps_pkg::StIdle);
  // The spacing is only changed between segments, never under one in flight.
  assign cfg_ready_o = (state_q == sps_pkg::StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 31'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      step_q <= cfg_data_i;
    end
  end

  for (genvar g = 0; g < sps_pkg::NumLanes; g++) begin : g_lane
    sps_lane u_lane (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .start_i (st[g]),
      .end_i   (en[g]),
      .sq_o    (sq[g]),
      .point_o (pt[g])
    );
  end

  sps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .rad_i   (sum_sq),
    .done_o  (sqrt_done),
    .len_o   (len)
  );

  sps_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (pt_valid),
    .ready_o     (pt_ready),
    .x_i         (pt[0]),
    .y_i         (pt[1]),
    .z_i         (pt[2]),
    .last_i      (is_last),
    .capped_i    (capped_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sps_pkg::StIdle;
      cnt_q    <= '0;
      n_q      <= '0;
      j_q      <= '0;
      capped_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      j_q      <= j_d;
      capped_q <= capped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

  // Sequencer: square, root, step count, per-axis division (skipped when n is zero), then emission.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    num_d      = num_q;
    n_d        = n_q;
    j_d        = j_q;
    capped_d   = capped_q;
    sqrt_start = 1'b0;
    pt_valid   = 1'b0;
    ctl        = '0;
    ctl.n      = n_q;
    case (state_q)
      sps_pkg::StIdle: begin
        if (in_valid_i) begin
          ctl.load = 1'b1;
          state_d  = sps_pkg::StSquare;
        end
      end
      sps_pkg::StSquare: begin
        state_d = sps_pkg::StSum;
      end
      sps_pkg::StSum: begin
        sqrt_start = 1'b1;
        state_d    = sps_pkg::StSqrt;
      end
      sps_pkg::StSqrt: begin
        if (sqrt_done) begin
          num_d    = {1'b0, len, 1'b0} + {5'b0, step_eff};
          cnt_d    = 6'(sps_pkg::StepW);
          n_d      = '0;
          capped_d = 1'b0;
          state_d  = sps_pkg::StNdiv;
        end
      end
      sps_pkg::StNdiv: begin
        // The first compare decides whether n reaches the limit.
        if (cnt_q == 6'(sps_pkg::StepW)) begin
          if ({2'b0, num_q} >= den_sh) begin
            n_d          = sps_pkg::StepW'(sps_pkg::MaxSteps);
            capped_d     = 1'b1;
            ctl.div_load = 1'b1;
            cnt_d        = 6'(sps_pkg::QuoW - 1);
            state_d      = sps_pkg::StLdiv;
          end else begin
            cnt_d = cnt_q - 6'd1;
          end
        end else begin
          if ({2'b0, num_q} >= den_sh) begin
            num_d = 36'({2'b0, num_q} - den_sh);
            n_d   = n_q | (sps_pkg::StepW'(1) << cnt_q);
          end
          if (cnt_q == '0) begin
            if (n_d == '0) begin
              ctl.n         = '0;
              ctl.emit_init = 1'b1;
              j_d           = '0;
              state_d       = sps_pkg::StEmit;
            end else begin
              ctl.div_load = 1'b1;
              cnt_d        = 6'(sps_pkg::QuoW - 1);
              state_d      = sps_pkg::StLdiv;
            end
          end else begin
            cnt_d = cnt_q - 6'd1;
          end
        end
      end
      sps_pkg::StLdiv: begin
        ctl.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = sps_pkg::StEmit;
          j_d     = '0;
        end else begin
          cnt_d = cnt_q - 6'd1;
        end
      end
      sps_pkg::StEmit: begin
        pt_valid = 1'b1;
        // The offset accumulator starts fresh on entry from the divider.
        if (pt_ready) begin
          if (is_last) begin
            state_d = sps_pkg::StIdle;
          end else begin
            ctl.emit_step = 1'b1;
            j_d           = j_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = sps_pkg::StIdle;
      end
    endcase
    // Clear the offset accumulator on the last divider cycle.
    if (state_q == sps_pkg::StLdiv && cnt_q == '0) begin
      ctl.emit_init = 1'b1;
    end
  end

endmodule

### tb/tb_segment_point_sampler.sv
// Testbench for the segment point sampler: random and directed segments with
// a scoreboard class that predicts every sampled point. Depends on sps_pkg
// and the segment_point_sampler RTL.
module tb_segment_point_sampler;
  timeunit 1ns;
  timeprecision 1ps;

  // Scoreboard: predicts the sampled points of each accepted segment and
  // checks every point that the block hands out against the oldest one.
  class sample_scoreboard;
    sps_pkg::pt_out_t pending_points[$];
    logic [30:0]      spacing;
    int               errors;

    function new();
      spacing = 31'd65536;
      errors  = 0;
    endfunction

    // Appends one expected point behind the ones already waiting.
    function void add_expected(sps_pkg::pt_out_t pt);
      pending_points = {pending_points, pt};
    endfunction

    // Rounded integer square root of a value below 2^66.
    function logic [32:0] round_root(logic [65:0] rad);
      logic [32:0]  r;
      logic [32:0]  c;
      logic [67:0]  sq;
      logic [67:0]  rem;
      r = '0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (33'd1 << b);
        sq = {35'd0, c} * {35'd0, c};
        if (sq <= {2'b00, rad}) r = c;
      end
      rem = {2'b00, rad} - {35'd0, r} * {35'd0, r};
      if (rem > {35'd0, r}) r = r + 33'd1;
      return r;
    endfunction

    // Notes one accepted segment and queues its expected points.
    function void note_segment(sps_pkg::seg_in_t seg);
      logic signed [33:0] start_c[3];
      logic signed [33:0] delta[3];
      logic [32:0]        dmag[3];
      logic [65:0]        rad;
      logic [32:0]        len;
      logic [33:0]        step;
      logic [40:0]        nwide;
      int                 n;
      logic               cap;
      logic [40:0]        m;
      logic [40:0]        q;
      logic signed [33:0] p;
      sps_pkg::pt_out_t   pt;
      start_c[0] = seg.start_x; start_c[1] = seg.start_y; start_c[2] = seg.start_z;
      delta[0] = 34'(seg.end_x) - start_c[0];
      delta[1] = 34'(seg.end_y) - start_c[1];
      delta[2] = 34'(seg.end_z) - start_c[2];
      rad = '0;
      for (int k = 0; k < 3; k++) begin
        dmag[k] = delta[k] < 0 ? 33'(-delta[k]) : 33'(delta[k]);
        rad = rad + {33'd0, dmag[k]} * {33'd0, dmag[k]};
      end
      len  = round_root(rad);
      step = (spacing == 0) ? 34'd1 : {3'd0, spacing};
      nwide = (2 * {8'd0, len} + {7'd0, step}) / (2 * {7'd0, step});
      cap = nwide > sps_pkg::MaxSteps;
      n = cap ? sps_pkg::MaxSteps : int'(nwide);
      if (n == 0) begin
        pt.point_x = seg.start_x; pt.point_y = seg.start_y; pt.point_z = seg.start_z;
        pt.last = 1'b1;
        pt.capped = 1'b0;
        add_expected(pt);
        return;
      end
      for (int j = 0; j <= n; j++) begin
        for (int k = 0; k < 3; k++) begin
          m = {8'd0, dmag[k]} * j;
          q = (2 * m + n) / (2 * n);
          p = start_c[k] + (delta[k] < 0 ? -34'(q) : 34'(q));
          if (k == 0) pt.point_x = p[31:0];
          else if (k == 1) pt.point_y = p[31:0];
          else pt.point_z = p[31:0];
        end
        pt.last = (j == n);
        pt.capped = cap;
        add_expected(pt);
      end
    endfunction

    // Compares one handed-out point with the oldest expectation.
    function void check_point(sps_pkg::pt_out_t got);
      sps_pkg::pt_out_t want;
      if (pending_points.size() == 0) begin
        $error("point with no expectation: %p", got);
        errors++;
        return;
      end
      want = pending_points.pop_front();
      if (got.point_x !== want.point_x) begin
        $error("point_x: expected %0d, got %0d", want.point_x, got.point_x);
        errors++;
      end
      if (got.point_y !== want.point_y) begin
        $error("point_y: expected %0d, got %0d", want.point_y, got.point_y);
        errors++;
      end
      if (got.point_z !== want.point_z) begin
        $error("point_z: expected %0d, got %0d", want.point_z, got.point_z);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.capped !== want.capped) begin
        $error("capped: expected %0b, got %0b", want.capped, got.capped);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_ready_o;
  sps_pkg::seg_in_t in_i = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  sps_pkg::pt_out_t out_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [30:0]      cfg_data_i = '0;

  sample_scoreboard board = new();
  bit               stimulus_done = 1'b0;

  always #1 clk_i = ~clk_i;

  segment_point_sampler dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i,
    .out_valid_o, .out_ready_i, .out_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Segments and points are noted at the rising edge, where they are taken.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) board.note_segment(in_i);
    if (rst_ni && out_valid_o && out_ready_i) board.check_point(out_o);
  end

  // The consumer stalls a random number of cycles before each point; a
  // quarter of the time it runs flat out so back-to-back transfers occur.
  initial begin
    int wait_cycles;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      wait_cycles = ($urandom_range(3) == 0) ? 0 : $urandom_range(18);
      if (wait_cycles > 0) begin
        out_ready_i <= 1'b0;
        repeat (wait_cycles) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Sends one segment after a random gap, or at once when no_gap is set, and holds it until it is taken.
  // Valid stays high past the accepting edge only when the next segment
  // follows at once; otherwise it drops at the start of the gap.
  task automatic send_segment(sps_pkg::seg_in_t seg, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(18);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_i <= seg;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Waits for every expected point, then lets the block settle before a
  // register write.
  task automatic drain_points();
    in_valid_i <= 1'b0;
    while (board.pending_points.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic write_spacing(logic [30:0] value);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.spacing = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7fff_ffff - $urandom_range(3);
      2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // Segments whose length is a few multiples of the spacing, so that n lands
  // in the uncapped range most of the time.
  function automatic sps_pkg::seg_in_t rand_segment(logic [30:0] spacing);
    sps_pkg::seg_in_t s;
    int unsigned reach;
    s.start_x = rand_coord(); s.start_y = rand_coord(); s.start_z = rand_coord();
    if ($urandom_range(3) == 0) begin
      s.end_x = rand_coord(); s.end_y = rand_coord(); s.end_z = rand_coord();
    end else begin
      reach = (spacing > 31'd100_000_000) ? 32'h7fff_ffff : spacing * $urandom_range(20);
      s.end_x = s.start_x + ($urandom_range(reach) - reach / 2);
      s.end_y = s.start_y + ($urandom_range(reach) - reach / 2);
      s.end_z = s.start_z + ($urandom_range(reach) - reach / 2);
    end
    return s;
  endfunction

  initial begin
    sps_pkg::seg_in_t seg;
    logic [30:0]      spacings[6];
    spacings = '{31'd65536, 31'd0, 31'd1, 31'h7fff_ffff, 31'd300_000, 31'd12_345};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: a point segment, unit steps, segments just under and at half
    // a step, the full range, and the largest spans in each axis.
    send_segment('{default: '0}, 1'b0);
    send_segment('{0, 0, 0, 32'sd196608, 0, 0}, 1'b0);
    send_segment('{0, 0, 0, 32'sd32767, 0, 0}, 1'b0);
    send_segment('{0, 0, 0, 32'sd32768, 0, 0}, 1'b0);
    send_segment('{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0);
    send_segment('{32'sh7fff_ffff, 0, 32'sh8000_0000,
                   32'sh8000_0000, 32'sd65536, 32'sh7fff_ffff}, 1'b1);
    send_segment('{32'sd100, -32'sd300, 32'sd5, -32'sd200000, 32'sd150000, 32'sd70000}, 1'b1);

    // Hold off until the block has handed out everything before moving on.
    drain_points();

    for (int phase = 0; phase < 6; phase++) begin
      write_spacing(spacings[phase]);
      if (phase == 1 || phase == 3) begin
        send_segment('{default: '0}, 1'b0);
        send_segment('{0, 0, 0, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff}, 1'b0);
      end
      for (int i = 0; i < 30; i++) begin
        seg = rand_segment(spacings[phase]);
        send_segment(seg, ($urandom_range(4) == 0));
      end
      drain_points();
    end
    stimulus_done = 1'b1;
  end

  initial begin
    wait (stimulus_done);
    repeat (200) @(negedge clk_i);
    if (board.errors == 0 && board.pending_points.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Generous bound: about 200 segments at 64 points, each point stalled by
  // the consumer, plus the processing of each segment and sender gaps.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
